>>> rtl/core/cyclic_rotation_sort_dedup_top_macros.svh
// assertion macros of the rotation sort datapath
// expects signals named clock and reset in the including module
`ifndef CYCLIC_ROTATION_SORT_DEDUP_TOP_MACROS_SVH
`define CYCLIC_ROTATION_SORT_DEDUP_TOP_MACROS_SVH

// condition must hold at every edge outside reset
`define CRSD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// implication within the same edge
`define CRSD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/crsd_pkg.sv
// shared types, constants and the key function of the rotation sort block
// no dependencies
`default_nettype none
package crsd_pkg;

   localparam int unsigned MAX_WORD_LEN  = 16;
   localparam int unsigned MAX_ROTATIONS = 64;
   localparam int unsigned NUM_COLUMNS   = 16;
   localparam int unsigned ELEM_W        = 4;
   localparam int unsigned WORD_W        = 64;
   localparam int unsigned LEN_W         = 5;
   localparam int unsigned CNT_W         = 7;
   localparam int unsigned KEY_W         = 80;
   localparam int unsigned ENTRY_W       = WORD_W + LEN_W;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_RANGE    = 2'd2
   } crsd_status_type;

   typedef struct packed {
      logic load_en;
      logic rot_en;
      logic scan_start;
      logic scan_en;
      logic emit_pending;
      logic take_cand;
      logic emit_err;
      logic clear_set;
   } crsd_cmd_type;

   typedef struct packed {
      logic close_word;
      logic set_end;
      logic rot_done;
      logic eos_pending;
      logic scan_done;
      logic found;
      logic pending;
      logic slot_free;
   } crsd_stat_type;

   // sortable key: one 5 bit digit per element, element plus one, first element
   // most significant, zero past the end so a prefix ranks lower
   function automatic logic [KEY_W-1:0] crsd_key(input logic [WORD_W-1:0] word,
                                                 input logic [LEN_W-1:0] len);
      logic [KEY_W-1:0] key;
      key = '0;
      for (int i = 0; i < 16; i++) begin
         if (5'(i) < len) begin
            key[KEY_W-1-5*i -: 5] = {1'b0, word[4*i +: 4]} + 5'd1;
         end
      end
      return key;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/cyclic_rotation_sort_dedup_top.sv
// load: one element per cycle while the sequencer waits for elements; closing a word of length L
// stalls input while its L rotations are written; set end with n rotations and d distinct words:
// d+1 scans of all n rotations, one result per scan after the first, each result waiting for a free
// output slot; an error set loads its single result in the error output state once the slot is free
// reset is synchronous, active high: clears counters, error and handshake state,
// column_count returns to 16; the rotation ram needs no clearing
`default_nettype none
module cyclic_rotation_sort_dedup_top
   import crsd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // configuration write
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [LEN_W-1:0]    csr_column_count,
   // element input
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [ELEM_W-1:0]   req_element,
   input  wire logic                req_end_of_word,
   input  wire logic                req_end_of_set,
   // result output
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [WORD_W-1:0]   rsp_word_bits,
   output logic      [LEN_W-1:0]    rsp_word_length,
   output logic      [ELEM_W-1:0]   rsp_row,
   output logic      [1:0]          rsp_status,
   output logic                     rsp_last
);

   crsd_cmd_type  cmd;
   crsd_stat_type stat;
   logic          load_ready;
   logic          req_fire;

   // the user must issue config writes only while idle; the block does not enforce this, so always ready
   assign csr_ready = 1'b1;

   // input taken only while the sequencer waits for elements
   assign req_stall = !load_ready;
   assign req_fire  = req_valid && load_ready;

   crsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .stat       (stat),
      .load_ready (load_ready),
      .cmd        (cmd)
   );

   // datapath holds the word builder, rotation ram, scan and output register
   crsd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_column_count (csr_column_count),
      .req_element      (req_element),
      .req_end_of_word  (req_end_of_word),
      .req_end_of_set   (req_end_of_set),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_word_bits    (rsp_word_bits),
      .rsp_word_length  (rsp_word_length),
      .rsp_row          (rsp_row),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

>>> rtl/core/crsd_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module crsd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/crsd_ctrl.sv
// sequencer of the rotation sort block: load, rotate, scan, emit
// depends on crsd_pkg
`default_nettype none
module crsd_ctrl
   import crsd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_fire,
   input  wire crsd_stat_type stat,
   output logic               load_ready,
   output crsd_cmd_type       cmd
);

   typedef enum logic [4:0] {
      ST_LOAD   = 5'b00001,
      ST_ROTATE = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_ERROUT = 5'b10000
   } crsd_state_type;

   crsd_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.load_en = req_fire;
            if (req_fire && stat.close_word) begin
               state_in = ST_ROTATE;
            end else if (req_fire && stat.set_end) begin
               state_in = ST_ERROUT;
            end
         end
         ST_ROTATE: begin
            cmd.rot_en = 1'b1;
            if (stat.rot_done) begin
               if (stat.eos_pending) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!stat.pending || stat.slot_free) begin
               cmd.emit_pending = stat.pending;
               if (stat.found) begin
                  cmd.take_cand  = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  cmd.clear_set = 1'b1;
                  state_in      = ST_LOAD;
               end
            end
         end
         ST_ERROUT: begin
            if (stat.slot_free) begin
               cmd.emit_err  = 1'b1;
               cmd.clear_set = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign load_ready = (state_ff == ST_LOAD);

endmodule
`default_nettype wire

>>> rtl/core/crsd_dp.sv
// datapath of the rotation sort block: word build, rotation store, min scan, output
// depends on crsd_pkg, crsd_ram and the assertion macro header
`default_nettype none
`include "cyclic_rotation_sort_dedup_top_macros.svh"
module crsd_dp
   import crsd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   input  wire logic [LEN_W-1:0]    csr_column_count,
   input  wire logic [ELEM_W-1:0]   req_element,
   input  wire logic                req_end_of_word,
   input  wire logic                req_end_of_set,
   input  wire logic                rsp_stall,
   input  wire crsd_cmd_type        cmd,
   output crsd_stat_type            stat,
   output logic                     rsp_valid,
   output logic      [WORD_W-1:0]   rsp_word_bits,
   output logic      [LEN_W-1:0]    rsp_word_length,
   output logic      [ELEM_W-1:0]   rsp_row,
   output logic      [1:0]          rsp_status,
   output logic                     rsp_last
);

   logic [LEN_W-1:0]   cc_ff;
   logic [CNT_W-1:0]   count_ff, wr_ptr_ff, rd_cnt_ff;
   crsd_status_type    err_ff, err_in;
   logic [WORD_W-1:0]  word_ff, word_in, rot_ff, rot_in;
   logic [LEN_W-1:0]   wlen_ff, wlen_in, rlen_ff, rk_ff;
   logic               eos_ff, rdv_ff;
   logic               bad, ovf, store;
   logic [5:0]         rot_amt;
   logic [LEN_W-1:0]   rlen_m1;
   logic [ENTRY_W-1:0] rd_data;
   logic [KEY_W-1:0]   rd_key, best_key_ff, prev_key_ff;
   logic [WORD_W-1:0]  best_word_ff, pend_word_ff;
   logic [LEN_W-1:0]   best_len_ff, pend_len_ff;
   logic               found_ff, has_prev_ff, pend_ff;
   logic               rd_en, better;
   logic               out_valid_ff, out_last_ff;
   logic [WORD_W-1:0]  out_word_ff;
   logic [LEN_W-1:0]   out_len_ff;
   crsd_status_type    out_status_ff;

   // element checks and word append
   always_comb begin
      bad     = ({1'b0, req_element} >= cc_ff);
      ovf     = (count_ff == CNT_W'(MAX_ROTATIONS)) || (wlen_ff == LEN_W'(MAX_WORD_LEN));
      store   = (err_ff == STATUS_OK) && !bad && !ovf;
      err_in  = err_ff;
      if (err_ff == STATUS_OK) begin
         if (bad) begin
            err_in = STATUS_RANGE;
         end else if (ovf) begin
            err_in = STATUS_OVERFLOW;
         end
      end
      word_in = word_ff | (WORD_W'(req_element) << {wlen_ff[3:0], 2'b00});
      wlen_in = wlen_ff + LEN_W'(1);
   end

   // one step of cyclic rotation within the word length
   assign rlen_m1 = rlen_ff - LEN_W'(1);
   assign rot_amt = {rlen_m1[3:0], 2'b00};
   assign rot_in  = (rot_ff >> ELEM_W) | (WORD_W'(rot_ff[ELEM_W-1:0]) << rot_amt);

   assign rd_en  = cmd.scan_en && (rd_cnt_ff < count_ff);
   assign rd_key = crsd_key(rd_data[WORD_W-1:0], rd_data[ENTRY_W-1:WORD_W]);
   assign better = rdv_ff && (!has_prev_ff || (rd_key > prev_key_ff))
                          && (!found_ff || (rd_key < best_key_ff));

   crsd_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ROTATIONS)) u_rot_ram (
      .clock   (clock),
      .wr_en   (cmd.rot_en),
      .wr_addr (wr_ptr_ff[CNT_W-2:0]),
      .wr_data ({rlen_ff, rot_ff}),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff[CNT_W-2:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff        <= LEN_W'(NUM_COLUMNS);
         count_ff     <= '0;
         wr_ptr_ff    <= '0;
         err_ff       <= STATUS_OK;
         word_ff      <= '0;
         wlen_ff      <= '0;
         rdv_ff       <= 1'b0;
         found_ff     <= 1'b0;
         has_prev_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            cc_ff <= csr_column_count;
         end
         if (cmd.load_en) begin
            err_ff <= err_in;
            if (store) begin
               word_ff  <= word_in;
               wlen_ff  <= wlen_in;
               count_ff <= count_ff + CNT_W'(1);
            end
         end
         if (cmd.rot_en) begin
            wr_ptr_ff <= wr_ptr_ff + CNT_W'(1);
            if (stat.rot_done) begin
               word_ff <= '0;
               wlen_ff <= '0;
            end
         end
         rdv_ff <= rd_en;
         if (cmd.scan_start) begin
            found_ff <= 1'b0;
         end else if (better) begin
            found_ff <= 1'b1;
         end
         if (cmd.take_cand) begin
            has_prev_ff <= 1'b1;
            pend_ff     <= 1'b1;
         end
         if (cmd.emit_pending || cmd.emit_err) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd.clear_set) begin
            count_ff    <= '0;
            wr_ptr_ff   <= '0;
            err_ff      <= STATUS_OK;
            word_ff     <= '0;
            wlen_ff     <= '0;
            has_prev_ff <= 1'b0;
            pend_ff     <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_en && store) begin
         rot_ff  <= word_in;
         rlen_ff <= wlen_in;
         rk_ff   <= '0;
         eos_ff  <= req_end_of_set;
      end else if (cmd.rot_en) begin
         rot_ff <= rot_in;
         rk_ff  <= rk_ff + LEN_W'(1);
      end
      if (cmd.scan_start) begin
         rd_cnt_ff <= '0;
      end else if (rd_en) begin
         rd_cnt_ff <= rd_cnt_ff + CNT_W'(1);
      end
      if (better) begin
         best_key_ff  <= rd_key;
         best_word_ff <= rd_data[WORD_W-1:0];
         best_len_ff  <= rd_data[ENTRY_W-1:WORD_W];
      end
      if (cmd.take_cand) begin
         prev_key_ff  <= best_key_ff;
         pend_word_ff <= best_word_ff;
         pend_len_ff  <= best_len_ff;
      end
      if (cmd.emit_pending) begin
         out_word_ff   <= pend_word_ff;
         out_len_ff    <= pend_len_ff;
         out_status_ff <= STATUS_OK;
         out_last_ff   <= !found_ff;
      end else if (cmd.emit_err) begin
         out_word_ff   <= '0;
         out_len_ff    <= '0;
         out_status_ff <= err_ff;
         out_last_ff   <= 1'b1;
      end
   end

   always_comb begin
      stat.close_word  = (err_in == STATUS_OK) && (req_end_of_word || req_end_of_set);
      stat.set_end     = req_end_of_set;
      stat.rot_done    = (rk_ff == rlen_m1);
      stat.eos_pending = eos_ff;
      stat.scan_done   = (rd_cnt_ff == count_ff) && !rdv_ff;
      stat.found       = found_ff;
      stat.pending     = pend_ff;
      stat.slot_free   = !out_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_word_bits   = out_word_ff;
   assign rsp_word_length = out_len_ff;
   assign rsp_row         = out_word_ff[ELEM_W-1:0];
   assign rsp_status      = out_status_ff;
   assign rsp_last        = out_last_ff;

   `CRSD_ASSERT_ALWAYS(a_ptr_le_count, wr_ptr_ff <= count_ff, "rotation pointer passed count")
   `CRSD_ASSERT_ALWAYS(a_count_max, count_ff <= CNT_W'(MAX_ROTATIONS), "element count overflow")
   `CRSD_ASSERT_IMPL(a_err_last, out_valid_ff && out_status_ff != STATUS_OK, out_last_ff,
                     "error result without last")
   `CRSD_ASSERT_IMPL(a_emit_slot, cmd.emit_pending || cmd.emit_err, stat.slot_free,
                     "result loaded over a waiting result")

endmodule
`default_nettype wire
